>>> src/prc_pkg.sv
// Shared types and constants of the point rotate, project and clip block.
package prc_pkg;

  localparam int CoordW = 16;
  localparam int GlyphW = 8;
  localparam int TrigW  = 16;
  localparam int ColW   = 7;
  localparam int RowW   = 5;
  localparam int AddrW  = 11;

  // Widths of the rotation arithmetic; every product is kept exact.
  localparam int ProdW  = 32;
  localparam int RotW   = 33;
  localparam int DepthW = 34;
  localparam int DenW   = 33;

  // Depth offset of 5.0 in Q.22.
  localparam logic signed [DepthW-1:0] DepthOffset = DepthW'(5 * 4194304);

  localparam int PaddrW = 3;
  localparam int PdataW = 32;

  localparam logic signed [TrigW-1:0] SineReset   = 16'sd0;
  localparam logic signed [TrigW-1:0] CosineReset = 16'sd16384;

  typedef enum logic {
    REG_SINE   = 1'b0,
    REG_COSINE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [TrigW-1:0] angle_sine;
    logic signed [TrigW-1:0] angle_cosine;
  } cfg_t;

endpackage

>>> src/prc_if.sv
// Stream interfaces for the point input channel and the screen cell output channel.
interface prc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [prc_pkg::CoordW-1:0]   point_x;
  logic signed [prc_pkg::CoordW-1:0]   point_y;
  logic signed [prc_pkg::CoordW-1:0]   point_z;
  logic        [prc_pkg::GlyphW-1:0]   glyph;

  modport source (output valid, point_x, point_y, point_z, glyph, input ready);
  modport sink (input valid, point_x, point_y, point_z, glyph, output ready);
endinterface

interface prc_out_if;
  logic                              valid;
  logic                              ready;
  logic [prc_pkg::ColW-1:0]          screen_column;
  logic [prc_pkg::RowW-1:0]          screen_row;
  logic [prc_pkg::AddrW-1:0]         cell_address;
  logic [prc_pkg::GlyphW-1:0]        glyph_out;
  logic                              visible;

  modport source (output valid, screen_column, screen_row, cell_address, glyph_out, visible,
                  input ready);
  modport sink (input valid, screen_column, screen_row, cell_address, glyph_out, visible,
                output ready);
endinterface

>>> src/point_rotate_project_clip.sv
// Throughput: one point per cycle while out_chan stays ready; five transform stages, one
// divider stage per quotient bit and one output register, each stage moving on as soon as
// the next one has room.
// Reset clears all stage valid bits and sets the angle to sine 0.0 and cosine 1.0.
// Configuration writes are taken at any time, including right after reset.
module point_rotate_project_clip #(
  parameter int SCREEN_WIDTH     = 80,
  parameter int SCREEN_HEIGHT    = 25,
  parameter int PROJECTION_SCALE = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  prc_in_if.sink                        in_chan,
  prc_out_if.source                     out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prc_pkg::PaddrW-1:0]    paddr,
  input  logic [prc_pkg::PdataW-1:0]    pwdata,
  output logic [prc_pkg::PdataW-1:0]    prdata,
  output logic                          pready
);

  localparam int MaxDim = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int QuotW  = $clog2(MaxDim);
  localparam int RemW   = prc_pkg::DenW + QuotW;
  localparam int AfW    = 2 * QuotW;

  prc_pkg::cfg_t               cfg;
  logic                        tr_valid, tr_ready;
  logic [RemW-1:0]             num_x, num_y;
  logic [prc_pkg::DenW-1:0]    den;
  logic                        tr_vis;
  logic [prc_pkg::GlyphW-1:0]  tr_glyph;
  logic                        dv_valid, dv_ready;
  logic [QuotW-1:0]            quo_x, quo_y;
  logic                        dv_vis;
  logic [prc_pkg::GlyphW-1:0]  dv_glyph;

  prc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  prc_transform #(
    .SCREEN_WIDTH     (SCREEN_WIDTH),
    .SCREEN_HEIGHT    (SCREEN_HEIGHT),
    .PROJECTION_SCALE (PROJECTION_SCALE)
  ) u_transform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .in_chan (in_chan),
    .valid_o (tr_valid),
    .ready_i (tr_ready),
    .num_x_o (num_x),
    .num_y_o (num_y),
    .den_o   (den),
    .vis_o   (tr_vis),
    .glyph_o (tr_glyph)
  );

  prc_divider #(
    .QuotW (QuotW)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tr_valid),
    .ready_o (tr_ready),
    .num_x_i (num_x),
    .num_y_i (num_y),
    .den_i   (den),
    .vis_i   (tr_vis),
    .glyph_i (tr_glyph),
    .valid_o (dv_valid),
    .ready_i (dv_ready),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y),
    .vis_o   (dv_vis),
    .glyph_o (dv_glyph)
  );

  // Output register: cell address, and zeroing of invisible results.
  logic                        out_v_q;
  logic [AfW-1:0]              addr_full;
  logic [prc_pkg::ColW-1:0]    col_q;
  logic [prc_pkg::RowW-1:0]    row_q;
  logic [prc_pkg::AddrW-1:0]   addr_q;
  logic [prc_pkg::GlyphW-1:0]  glyph_q;
  logic                        vis_q;

  assign dv_ready  = !out_v_q || out_chan.ready;
  assign addr_full = AfW'(quo_y) * AfW'(SCREEN_WIDTH) + AfW'(quo_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (dv_ready) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_ready && dv_valid) begin
      col_q   <= dv_vis ? prc_pkg::ColW'(quo_x) : '0;
      row_q   <= dv_vis ? prc_pkg::RowW'(quo_y) : '0;
      addr_q  <= dv_vis ? prc_pkg::AddrW'(addr_full) : '0;
      glyph_q <= dv_glyph;
      vis_q   <= dv_vis;
    end
  end

  assign out_chan.valid         = out_v_q;
  assign out_chan.screen_column = col_q;
  assign out_chan.screen_row    = row_q;
  assign out_chan.cell_address  = addr_q;
  assign out_chan.glyph_out     = glyph_q;
  assign out_chan.visible       = vis_q;

endmodule

>>> src/prc_cfg_regs.sv
// APB-style register file holding the sine and cosine of the rotation angle.
module prc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prc_pkg::PaddrW-1:0]    paddr,
  input  logic [prc_pkg::PdataW-1:0]    pwdata,
  output logic [prc_pkg::PdataW-1:0]    prdata,
  output logic                          pready,
  output prc_pkg::cfg_t                 cfg_o
);

  logic signed [prc_pkg::TrigW-1:0] sine_q;
  logic signed [prc_pkg::TrigW-1:0] cosine_q;
  prc_pkg::reg_idx_e                reg_idx;
  logic                             wr_en;

  assign reg_idx = prc_pkg::reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sine_q   <= prc_pkg::SineReset;
      cosine_q <= prc_pkg::CosineReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        prc_pkg::REG_SINE:   sine_q   <= pwdata[prc_pkg::TrigW-1:0];
        prc_pkg::REG_COSINE: cosine_q <= pwdata[prc_pkg::TrigW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      prc_pkg::REG_SINE:   prdata = prc_pkg::PdataW'(sine_q);
      prc_pkg::REG_COSINE: prdata = prc_pkg::PdataW'(cosine_q);
      default:             prdata = '0;
    endcase
  end

  assign cfg_o.angle_sine   = sine_q;
  assign cfg_o.angle_cosine = cosine_q;

endmodule

>>> src/prc_transform.sv
// Rotation, depth offset, projection numerators and screen bound checks in five stages.
module prc_transform #(
  parameter int SCREEN_WIDTH     = 80,
  parameter int SCREEN_HEIGHT    = 25,
  parameter int PROJECTION_SCALE = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  prc_pkg::cfg_t                      cfg_i,
  prc_in_if.sink                             in_chan,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic [prc_pkg::DenW+$clog2((SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH
                                      : SCREEN_HEIGHT)-1:0] num_x_o,
  output logic [prc_pkg::DenW+$clog2((SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH
                                      : SCREEN_HEIGHT)-1:0] num_y_o,
  output logic [prc_pkg::DenW-1:0]           den_o,
  output logic                               vis_o,
  output logic [prc_pkg::GlyphW-1:0]         glyph_o
);

  localparam int MaxDim = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int QuotW  = $clog2(MaxDim);
  localparam int RemW   = prc_pkg::DenW + QuotW;
  localparam int SclW   = $clog2(PROJECTION_SCALE + 1) + 1;
  localparam int DimW   = $clog2(MaxDim + 1) + 1;
  localparam int MW     = (SclW > DimW) ? SclW : DimW;
  localparam int NW     = prc_pkg::DepthW + MW + 2;
  localparam int TyW    = prc_pkg::CoordW + SclW;
  localparam int Stages = 5;

  localparam logic signed [SclW-1:0] ScaleS   = SclW'(PROJECTION_SCALE);
  localparam logic signed [DimW-1:0] HalfWS   = DimW'(SCREEN_WIDTH / 2);
  localparam logic signed [DimW-1:0] HalfHS   = DimW'(SCREEN_HEIGHT / 2);
  localparam logic signed [DimW-1:0] WidthS   = DimW'(SCREEN_WIDTH);
  localparam logic signed [DimW-1:0] HeightS  = DimW'(SCREEN_HEIGHT);

  logic [Stages-1:0] v_q;
  logic [Stages-1:0] rdy;

  // Each stage takes new data when it is empty or the next stage moves on.
  assign rdy[Stages-1] = !v_q[Stages-1] || ready_i;
  for (genvar k = 0; k < Stages - 1; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  assign in_chan.ready = rdy[0];
  assign valid_o       = v_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= in_chan.valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 1: the four rotation products.
  logic signed [prc_pkg::ProdW-1:0]  xc_q, zs_q, xs_q, zc_q;
  logic signed [prc_pkg::CoordW-1:0] py1_q;
  logic        [prc_pkg::GlyphW-1:0] g1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_chan.valid) begin
      xc_q  <= prc_pkg::ProdW'(in_chan.point_x) * prc_pkg::ProdW'(cfg_i.angle_cosine);
      zs_q  <= prc_pkg::ProdW'(in_chan.point_z) * prc_pkg::ProdW'(cfg_i.angle_sine);
      xs_q  <= prc_pkg::ProdW'(in_chan.point_x) * prc_pkg::ProdW'(cfg_i.angle_sine);
      zc_q  <= prc_pkg::ProdW'(in_chan.point_z) * prc_pkg::ProdW'(cfg_i.angle_cosine);
      py1_q <= in_chan.point_y;
      g1_q  <= in_chan.glyph;
    end
  end

  // Stage 2: rotated x and depth in Q.22.
  logic signed [prc_pkg::RotW-1:0]   rx_q;
  logic signed [prc_pkg::DepthW-1:0] dep2_q;
  logic signed [prc_pkg::CoordW-1:0] py2_q;
  logic        [prc_pkg::GlyphW-1:0] g2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_q[0]) begin
      rx_q   <= prc_pkg::RotW'(xc_q) - prc_pkg::RotW'(zs_q);
      dep2_q <= prc_pkg::DepthW'(xs_q) + prc_pkg::DepthW'(zc_q) + prc_pkg::DepthOffset;
      py2_q  <= py1_q;
      g2_q   <= g1_q;
    end
  end

  // Stage 3: scaled terms, screen centers and screen limits times depth.
  logic signed [NW-1:0]              termx_q, basex_q, basey_q, limx3_q, limy3_q;
  logic signed [TyW-1:0]             termy_q;
  logic signed [prc_pkg::DepthW-1:0] dep3_q;
  logic        [prc_pkg::GlyphW-1:0] g3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2] && v_q[1]) begin
      termx_q <= NW'(rx_q) * NW'(ScaleS);
      termy_q <= TyW'(py2_q) * TyW'(ScaleS);
      basex_q <= NW'(dep2_q) * NW'(HalfWS);
      basey_q <= NW'(dep2_q) * NW'(HalfHS);
      limx3_q <= NW'(dep2_q) * NW'(WidthS);
      limy3_q <= NW'(dep2_q) * NW'(HeightS);
      dep3_q  <= dep2_q;
      g3_q    <= g2_q;
    end
  end

  // Stage 4: full numerators; y is scaled from Q8.8 to Q.22 here.
  logic signed [NW-1:0]              nx_q, ny_q, limx4_q, limy4_q;
  logic signed [prc_pkg::DepthW-1:0] dep4_q;
  logic        [prc_pkg::GlyphW-1:0] g4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3] && v_q[2]) begin
      nx_q    <= basex_q + termx_q;
      ny_q    <= basey_q - (NW'(termy_q) <<< 14);
      limx4_q <= limx3_q;
      limy4_q <= limy3_q;
      dep4_q  <= dep3_q;
      g4_q    <= g3_q;
    end
  end

  // Stage 5: a quotient lands in [0, limit) exactly when -depth < n < limit*depth.
  // Numerators in (-depth, 0) truncate to zero, so they enter the divider as zero.
  logic signed [NW-1:0]            neg_dep;
  logic                            vis_d;
  logic [RemW-1:0]                 num_x_d, num_y_d;
  logic [RemW-1:0]                 num_x_q, num_y_q;
  logic [prc_pkg::DenW-1:0]        den_q;
  logic                            vis_q;
  logic [prc_pkg::GlyphW-1:0]      g5_q;

  always_comb begin
    neg_dep = -NW'(dep4_q);
    vis_d   = (dep4_q > 0) && (nx_q > neg_dep) && (nx_q < limx4_q) &&
              (ny_q > neg_dep) && (ny_q < limy4_q);
    num_x_d = (vis_d && nx_q > 0) ? nx_q[RemW-1:0] : '0;
    num_y_d = (vis_d && ny_q > 0) ? ny_q[RemW-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4] && v_q[3]) begin
      num_x_q <= num_x_d;
      num_y_q <= num_y_d;
      den_q   <= dep4_q[prc_pkg::DenW-1:0];
      vis_q   <= vis_d;
      g5_q    <= g4_q;
    end
  end

  assign num_x_o = num_x_q;
  assign num_y_o = num_y_q;
  assign den_o   = den_q;
  assign vis_o   = vis_q;
  assign glyph_o = g5_q;

endmodule

>>> src/prc_divider.sv
// Pipelined restoring divider for column and row, one quotient bit per stage.
module prc_divider #(
  parameter int QuotW = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [prc_pkg::DenW+QuotW-1:0]    num_x_i,
  input  logic [prc_pkg::DenW+QuotW-1:0]    num_y_i,
  input  logic [prc_pkg::DenW-1:0]          den_i,
  input  logic                              vis_i,
  input  logic [prc_pkg::GlyphW-1:0]        glyph_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [QuotW-1:0]                  quo_x_o,
  output logic [QuotW-1:0]                  quo_y_o,
  output logic                              vis_o,
  output logic [prc_pkg::GlyphW-1:0]        glyph_o
);

  localparam int RemW = prc_pkg::DenW + QuotW;

  logic [QuotW-1:0]                v_q;
  logic [QuotW-1:0]                rdy;
  logic [QuotW-1:0]                v_in;
  logic [RemW-1:0]                 rem_x_q [QuotW];
  logic [RemW-1:0]                 rem_y_q [QuotW];
  logic [QuotW-1:0]                quo_x_q [QuotW];
  logic [QuotW-1:0]                quo_y_q [QuotW];
  logic [prc_pkg::DenW-1:0]        den_q   [QuotW];
  logic                            vis_q   [QuotW];
  logic [prc_pkg::GlyphW-1:0]      glyph_q [QuotW];

  assign rdy[QuotW-1] = !v_q[QuotW-1] || ready_i;
  for (genvar k = 0; k < QuotW - 1; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  assign v_in    = {v_q[QuotW-2:0], valid_i};
  assign ready_o = rdy[0];
  assign valid_o = v_q[QuotW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < QuotW; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  for (genvar s = 0; s < QuotW; s++) begin : g_stage
    localparam int Bit = QuotW - 1 - s;

    logic [RemW-1:0]            rx_in, ry_in, dsh;
    logic [QuotW-1:0]           qx_in, qy_in;
    logic [prc_pkg::DenW-1:0]   den_in;
    logic                       vis_in;
    logic [prc_pkg::GlyphW-1:0] g_in;
    logic                       bx, by;

    if (s == 0) begin : g_first
      assign rx_in  = num_x_i;
      assign ry_in  = num_y_i;
      assign qx_in  = '0;
      assign qy_in  = '0;
      assign den_in = den_i;
      assign vis_in = vis_i;
      assign g_in   = glyph_i;
    end else begin : g_next
      assign rx_in  = rem_x_q[s-1];
      assign ry_in  = rem_y_q[s-1];
      assign qx_in  = quo_x_q[s-1];
      assign qy_in  = quo_y_q[s-1];
      assign den_in = den_q[s-1];
      assign vis_in = vis_q[s-1];
      assign g_in   = glyph_q[s-1];
    end

    assign dsh = RemW'(den_in) << Bit;
    assign bx  = rx_in >= dsh;
    assign by  = ry_in >= dsh;

    always_ff @(posedge clk_i) begin
      if (rdy[s] && v_in[s]) begin
        rem_x_q[s] <= bx ? rx_in - dsh : rx_in;
        rem_y_q[s] <= by ? ry_in - dsh : ry_in;
        quo_x_q[s] <= qx_in | (QuotW'(bx) << Bit);
        quo_y_q[s] <= qy_in | (QuotW'(by) << Bit);
        den_q[s]   <= den_in;
        vis_q[s]   <= vis_in;
        glyph_q[s] <= g_in;
      end
    end
  end

  assign quo_x_o = quo_x_q[QuotW-1];
  assign quo_y_o = quo_y_q[QuotW-1];
  assign vis_o   = vis_q[QuotW-1];
  assign glyph_o = glyph_q[QuotW-1];

endmodule

>>> tb/sv/prc_cell_check.sv
// Watches the point and screen cell channels, predicts each screen cell and compares it.
module prc_cell_check #(
  parameter int SCREEN_WIDTH     = 80,
  parameter int SCREEN_HEIGHT    = 25,
  parameter int PROJECTION_SCALE = 20
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  prc_in_if                          in_mon,
  prc_out_if                         out_mon,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [prc_pkg::PaddrW-1:0] paddr,
  input  logic [prc_pkg::PdataW-1:0] pwdata,
  output int                         fail_count_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // The camera sits 5.0 behind the origin; in Q.22 like the rotated depth.
  localparam longint DepthOffsetQ22 = 64'sd5 * 64'sd4194304;
  localparam longint HalfWidth      = SCREEN_WIDTH / 2;
  localparam longint HalfHeight     = SCREEN_HEIGHT / 2;

  typedef struct packed {
    logic [prc_pkg::ColW-1:0]   screen_column;
    logic [prc_pkg::RowW-1:0]   screen_row;
    logic [prc_pkg::AddrW-1:0]  cell_address;
    logic [prc_pkg::GlyphW-1:0] glyph_out;
    logic                       visible;
  } cell_t;

  prc_pkg::cfg_t angle;
  cell_t         cell_q[$];

  function automatic cell_t project_point(input prc_pkg::cfg_t a,
                                          input logic signed [prc_pkg::CoordW-1:0] px,
                                          input logic signed [prc_pkg::CoordW-1:0] py,
                                          input logic signed [prc_pkg::CoordW-1:0] pz,
                                          input logic [prc_pkg::GlyphW-1:0] g);
    longint sx, sy, sz, sn, cs, rot_x, rot_y, rot_z, depth, col, row;
    bit     vis;
    cell_t  c;
    sx = px;
    sy = py;
    sz = pz;
    sn = a.angle_sine;
    cs = a.angle_cosine;
    rot_x = sx * cs - sz * sn;
    rot_z = sx * sn + sz * cs;
    rot_y = sy * 16384;
    depth = rot_z + DepthOffsetQ22;
    col = 0;
    row = 0;
    vis = 1'b0;
    // Nothing is divided for points at or behind the camera plane.
    if (depth > 0) begin
      col = (HalfWidth * depth + rot_x * PROJECTION_SCALE) / depth;
      row = (HalfHeight * depth - rot_y * PROJECTION_SCALE) / depth;
      vis = col >= 0 && col < SCREEN_WIDTH && row >= 0 && row < SCREEN_HEIGHT;
    end
    if (!vis) begin
      col = 0;
      row = 0;
    end
    c.screen_column = col[prc_pkg::ColW-1:0];
    c.screen_row    = row[prc_pkg::RowW-1:0];
    c.cell_address  = vis ? prc_pkg::AddrW'(row * SCREEN_WIDTH + col) : '0;
    c.glyph_out     = g;
    c.visible       = vis;
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cell_t want;
    bit    bad;
    if (!rst_ni) begin
      angle.angle_sine   <= 16'sd0;
      angle.angle_cosine <= 16'sd16384;
      cell_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Angle writes only happen while the pipeline is empty.
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (prc_pkg::reg_idx_e'(paddr[2]))
          prc_pkg::REG_SINE:   angle.angle_sine   <= pwdata[prc_pkg::TrigW-1:0];
          prc_pkg::REG_COSINE: angle.angle_cosine <= pwdata[prc_pkg::TrigW-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        cell_q.push_back(project_point(angle, in_mon.point_x, in_mon.point_y, in_mon.point_z,
                                       in_mon.glyph));
      end
      if (out_mon.valid && out_mon.ready) begin
        bad = 1'b0;
        if (cell_q.size() == 0) begin
          $display("%t: screen cell transaction with none expected (column %0d row %0d)",
                   $time, out_mon.screen_column, out_mon.screen_row);
          bad = 1'b1;
        end else begin
          want = cell_q.pop_front();
          if (out_mon.screen_column !== want.screen_column) begin
            $display("%t: screen_column expected %0d actual %0d", $time,
                     want.screen_column, out_mon.screen_column);
            bad = 1'b1;
          end
          if (out_mon.screen_row !== want.screen_row) begin
            $display("%t: screen_row expected %0d actual %0d", $time,
                     want.screen_row, out_mon.screen_row);
            bad = 1'b1;
          end
          if (out_mon.cell_address !== want.cell_address) begin
            $display("%t: cell_address expected %0d actual %0d", $time,
                     want.cell_address, out_mon.cell_address);
            bad = 1'b1;
          end
          if (out_mon.glyph_out !== want.glyph_out) begin
            $display("%t: glyph_out expected %0h actual %0h", $time,
                     want.glyph_out, out_mon.glyph_out);
            bad = 1'b1;
          end
          if (out_mon.visible !== want.visible) begin
            $display("%t: visible expected %0b actual %0b", $time,
                     want.visible, out_mon.visible);
            bad = 1'b1;
          end
        end
        if (bad) fail_count_o <= fail_count_o + 1;
      end
      pending_o <= cell_q.size();
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Top level of the testbench: clock, reset, angle writes, point traffic and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ScreenW        = 80;
  localparam int ScreenH        = 25;
  localparam int ProjScale      = 20;
  localparam int Latency        = 13;
  localparam int CycleLimit     = 400000;
  localparam int PointsPerPhase = 90;
  localparam int PhaseCount     = 14;
  localparam int HoldCycles     = 300;
  localparam int JunkW          = prc_pkg::PdataW - prc_pkg::TrigW;

  typedef struct packed {
    logic signed [prc_pkg::CoordW-1:0] x;
    logic signed [prc_pkg::CoordW-1:0] y;
    logic signed [prc_pkg::CoordW-1:0] z;
    logic [prc_pkg::GlyphW-1:0]        glyph;
  } point_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [prc_pkg::PaddrW-1:0] paddr;
  logic [prc_pkg::PdataW-1:0] pwdata;
  logic [prc_pkg::PdataW-1:0] prdata;
  logic                       pready;
  int                         fail_count;
  int                         pending;
  int                         hold_req;
  int                         hold_done;
  int                         burst_left;

  prc_in_if  in_chan ();
  prc_out_if out_chan ();

  point_rotate_project_clip #(
    .SCREEN_WIDTH    (ScreenW),
    .SCREEN_HEIGHT   (ScreenH),
    .PROJECTION_SCALE(ProjScale)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  prc_cell_check #(
    .SCREEN_WIDTH    (ScreenW),
    .SCREEN_HEIGHT   (ScreenH),
    .PROJECTION_SCALE(ProjScale)
  ) cell_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: stretches of different stall patterns, plus long hold-offs on request.
  initial begin
    int mode;
    int stretch;
    out_chan.ready <= 1'b0;
    hold_done = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req != hold_done) begin
        hold_done++;
        repeat (HoldCycles) begin
          out_chan.ready <= 1'b0;
          @(posedge clk_i);
        end
      end
      mode    = $urandom_range(3);
      stretch = $urandom_range(60, 5);
      for (int i = 0; i < stretch; i++) begin
        case (mode)
          0:       out_chan.ready <= 1'b1;
          1:       out_chan.ready <= 1'($urandom_range(1));
          2:       out_chan.ready <= ($urandom_range(3) == 0);
          default: out_chan.ready <= i[1];
        endcase
        @(posedge clk_i);
      end
    end
  end

  function automatic point_t random_point();
    int     kind;
    point_t p;
    kind = $urandom_range(9);
    p.glyph = prc_pkg::GlyphW'($urandom());
    if (kind < 6) begin
      // Object space around the origin, where most points land on screen.
      p.x = prc_pkg::CoordW'(int'($urandom_range(1024)) - 512);
      p.y = prc_pkg::CoordW'(int'($urandom_range(1024)) - 512);
      p.z = prc_pkg::CoordW'(int'($urandom_range(1024)) - 512);
    end else if (kind < 8) begin
      p.x = prc_pkg::CoordW'(int'($urandom_range(4096)) - 2048);
      p.y = prc_pkg::CoordW'(int'($urandom_range(4096)) - 2048);
      p.z = prc_pkg::CoordW'(int'($urandom_range(4096)) - 2048);
    end else if (kind == 8) begin
      p.x = prc_pkg::CoordW'($urandom());
      p.y = prc_pkg::CoordW'($urandom());
      p.z = prc_pkg::CoordW'($urandom());
    end else begin
      case ($urandom_range(4))
        0:       p.x = 16'sh8000;
        1:       p.x = 16'sh7fff;
        2:       p.x = 16'sd0;
        3:       p.x = -16'sd1280;
        default: p.x = -16'sd1;
      endcase
      case ($urandom_range(4))
        0:       p.y = 16'sh8000;
        1:       p.y = 16'sh7fff;
        2:       p.y = 16'sd0;
        3:       p.y = 16'sd794;
        default: p.y = -16'sd1;
      endcase
      case ($urandom_range(4))
        0:       p.z = 16'sh8000;
        1:       p.z = 16'sh7fff;
        2:       p.z = 16'sd0;
        3:       p.z = -16'sd1280;
        default: p.z = -16'sd1279;
      endcase
    end
    return p;
  endfunction

  // Offers one point, after a random gap when a burst has run out.
  task automatic send_point(input point_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(3) == 0 ? $urandom_range(40, 10) : $urandom_range(6, 1);
      gap = $urandom_range(2) == 0 ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        {in_chan.point_x, in_chan.point_y, in_chan.point_z, in_chan.glyph} <= random_point();
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_chan.valid   <= 1'b1;
    in_chan.point_x <= p.x;
    in_chan.point_y <= p.y;
    in_chan.point_z <= p.z;
    in_chan.glyph   <= p.glyph;
    @(posedge clk_i);
    while (!in_chan.ready) @(posedge clk_i);
  endtask

  // Drains the pipeline so that the angle can be changed safely.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic write_angle(input prc_pkg::reg_idx_e idx,
                             input logic [prc_pkg::TrigW-1:0] value);
    logic [JunkW-1:0] junk;
    junk = JunkW'($urandom());
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= prc_pkg::PaddrW'({idx, 2'b00});
    pwdata  <= {junk, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    point_t                           directed_q[$];
    logic signed [prc_pkg::TrigW-1:0] sine;
    logic signed [prc_pkg::TrigW-1:0] cosine;
    real                              theta;
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_chan.valid   <= 1'b0;
    in_chan.point_x <= '0;
    in_chan.point_y <= '0;
    in_chan.point_z <= '0;
    in_chan.glyph   <= '0;
    hold_req        <= 0;
    burst_left       = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed points at the reset angle (no rotation), depth offset 5.0.
    directed_q.push_back('{16'sd0, 16'sd0, 16'sd0, 8'h00});
    directed_q.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 8'hff});
    directed_q.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 8'h80});
    directed_q.push_back('{16'sh7fff, 16'sh8000, 16'sd0, 8'h01});
    directed_q.push_back('{16'sh8000, 16'sh7fff, 16'sh7fff, 8'h7f});
    directed_q.push_back('{16'sd0, 16'sd0, -16'sd1280, 8'h2a});
    directed_q.push_back('{16'sd0, 16'sd0, -16'sd1281, 8'h2b});
    directed_q.push_back('{16'sd256, 16'sd256, -16'sd1279, 8'h2c});
    directed_q.push_back('{16'sd0, 16'sd0, -16'sd1279, 8'h2d});
    // Sums just below zero truncate to the first column or row.
    directed_q.push_back('{-16'sd2586, 16'sd0, 16'sd0, 8'h41});
    directed_q.push_back('{16'sd0, 16'sd794, 16'sd0, 8'h42});
    directed_q.push_back('{-16'sd2586, 16'sd794, 16'sd0, 8'h43});
    // Last column and last row, then one step past each edge of the screen.
    directed_q.push_back('{16'sd2534, -16'sd794, 16'sd0, 8'h44});
    directed_q.push_back('{16'sd2560, 16'sd0, 16'sd0, 8'h45});
    directed_q.push_back('{-16'sd2624, 16'sd0, 16'sd0, 8'h46});
    directed_q.push_back('{16'sd0, -16'sd832, 16'sd0, 8'h47});
    directed_q.push_back('{16'sd0, 16'sd832, 16'sd0, 8'h48});
    directed_q.push_back('{16'sd512, -16'sd512, 16'sd512, 8'h55});
    directed_q.push_back('{-16'sd1, -16'sd1, -16'sd1, 8'haa});
    foreach (directed_q[i]) send_point(directed_q[i]);
    drain();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin sine = 16'sd0;      cosine = 16'sd16384;  end
        1: begin sine = 16'sd16384;  cosine = 16'sd0;      end
        2: begin sine = -16'sd16384; cosine = 16'sd0;      end
        3: begin sine = 16'sd0;      cosine = -16'sd16384; end
        4: begin sine = 16'sd16384;  cosine = 16'sd16384;  end
        5: begin sine = -16'sd16384; cosine = -16'sd16384; end
        6: begin sine = 16'sh7fff;   cosine = 16'sh8000;   end
        12, 13: begin
          sine   = prc_pkg::TrigW'($urandom());
          cosine = prc_pkg::TrigW'($urandom());
        end
        default: begin
          theta  = $urandom_range(3599) * 3.14159265358979 / 1800.0;
          sine   = prc_pkg::TrigW'($rtoi($sin(theta) * 16384.0));
          cosine = prc_pkg::TrigW'($rtoi($cos(theta) * 16384.0));
        end
      endcase
      write_angle(prc_pkg::REG_SINE, sine);
      write_angle(prc_pkg::REG_COSINE, cosine);
      @(posedge clk_i);
      // Let the output side stall long enough to back up the whole pipeline.
      if (phase == 2 || phase == 9) hold_req <= hold_req + 1;
      for (int i = 0; i < PointsPerPhase; i++) send_point(random_point());
      drain();
    end

    repeat (3 * Latency) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
src/prc_pkg.sv
src/prc_if.sv
src/prc_cfg_regs.sv
src/prc_transform.sv
src/prc_divider.sv
src/point_rotate_project_clip.sv
tb/sv/prc_cell_check.sv
tb/sv/testbench.sv
